// ===== rtl/core/fermion_occupation_word_ops_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops - assertion macros
// Shared property macros for the checker; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef FERMION_OCCUPATION_WORD_OPS_UNIT_DEFINES_SVH
`define FERMION_OCCUPATION_WORD_OPS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FOWO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fowo same-cycle check failed");

// next-cycle implication, checked out of reset
`define FOWO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fowo next-cycle check failed");

`endif

// ===== rtl/core/fowo_pkg.sv =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops - package
// Operation and status codes, word layouts, command/status structs, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fowo_pkg;

    // default for the orbital limit
    localparam int MAX_ORBITALS_DEF = 64;

    // field widths
    localparam int OP_W    = 4;
    localparam int IDX_W   = 6;
    localparam int END_W   = 7;
    localparam int WORD_W  = 64;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 7;
    localparam int ADDR_W  = 1;
    localparam int ACC_W   = 7;
    localparam int CNT_W   = 2;
    localparam int CHUNK_W = 16;

    // input word layout
    localparam int IN_OP_LSB   = 0;
    localparam int IN_IDX_LSB  = IN_OP_LSB + OP_W;
    localparam int IN_END_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_WORD_LSB = IN_END_LSB + END_W;
    localparam int IN_BITS     = IN_WORD_LSB + WORD_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output word layout
    localparam int OUT_STAT_LSB  = 0;
    localparam int OUT_FLAG_POS  = OUT_STAT_LSB + STAT_W;
    localparam int OUT_VALUE_LSB = OUT_FLAG_POS + 1;
    localparam int OUT_SIGN_POS  = OUT_VALUE_LSB + WORD_W;
    localparam int OUT_BITS      = OUT_SIGN_POS + 1;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd0;
    localparam logic [OP_W-1:0] OP_CREATE     = 4'd1;
    localparam logic [OP_W-1:0] OP_ANNIHILATE = 4'd2;
    localparam logic [OP_W-1:0] OP_TEST       = 4'd3;
    localparam logic [OP_W-1:0] OP_SLICE      = 4'd4;
    localparam logic [OP_W-1:0] OP_COUNT_DIFF = 4'd5;
    localparam logic [OP_W-1:0] OP_LIST_DIFF  = 4'd6;
    localparam logic [OP_W-1:0] OP_LIST_MATCH = 4'd7;
    localparam logic [OP_W-1:0] OP_LIST_OCC   = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_NA        = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE     = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_MISMATCH  = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_BAD_SLICE = 3'd4;

    // register indexes
    localparam logic [ADDR_W-1:0] CFG_ORBITAL_COUNT  = 1'd0;
    localparam logic [ADDR_W-1:0] CFG_ELECTRON_COUNT = 1'd1;

    // operation classes seen by the controller
    typedef enum logic [1:0] {
        CLASS_SINGLE = 2'd0,
        CLASS_COUNT  = 2'd1,
        CLASS_LIST   = 2'd2
    } t_op_class;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic prep;
        logic count_step;
        logic emit_single;
        logic emit_list;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op_class op_class;
        logic      out_free;
        logic      list_last;
    } t_sts;

    // popcount of one chunk
    function automatic logic [4:0] popcount16(input logic [CHUNK_W-1:0] v);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            c = c + 5'(v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fowo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops - controller
// Sequences accept, decode, chunked popcount, single result and list runs.
// ----------------------------------------------------------------------------
`default_nettype none

module fowo_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_valid,
    input  fowo_pkg::t_sts    i_sts,
    output logic              o_s_ready,
    output fowo_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_SINGLE = 3'd3;
    localparam logic [2:0] S_LIST   = 3'd4;

    localparam logic [fowo_pkg::CNT_W-1:0] CNT_LAST = '1;

    logic [2:0]                 r_state, n_state;
    logic [fowo_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                unique case (i_sts.op_class)
                    fowo_pkg::CLASS_COUNT: n_state = S_COUNT;
                    fowo_pkg::CLASS_LIST:  n_state = S_LIST;
                    default:               n_state = S_SINGLE;
                endcase
            end
            S_COUNT: begin
                o_cmd.count_step = 1'b1;
                n_cnt            = r_cnt + fowo_pkg::CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_SINGLE;
                end
            end
            S_SINGLE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_list = 1'b1;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fowo_dp.sv =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops - datapath
// Occupation word, sign, config registers, work registers, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fowo_dp #(
    parameter int MAX_ORBITALS = fowo_pkg::MAX_ORBITALS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  fowo_pkg::t_cmd                      i_cmd,
    output fowo_pkg::t_sts                      o_sts,
    input  wire                                 i_cfg_wr_en,
    input  wire  [fowo_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  wire  [fowo_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  wire  [fowo_pkg::IN_DATA_W-1:0]      i_s_data,
    input  wire                                 i_m_ready,
    output logic                                o_m_valid,
    output logic [fowo_pkg::OUT_DATA_W-1:0]     o_m_data,
    output logic                                o_m_user,
    output logic                                o_m_last
);

    localparam int WW = fowo_pkg::WORD_W;
    localparam int KW = fowo_pkg::END_W;
    localparam int PAD_W = fowo_pkg::OUT_DATA_W - fowo_pkg::OUT_BITS;
    localparam logic [KW-1:0] K_MAX = KW'(MAX_ORBITALS);

    // architectural state
    logic [WW-1:0] r_occ, n_occ;
    logic          r_sign, n_sign;
    logic [KW-1:0] r_orbital_count;
    logic [KW-1:0] r_electron_count;

    // item and work registers
    logic [fowo_pkg::OP_W-1:0]  r_op;
    logic [fowo_pkg::IDX_W-1:0] r_idx;
    logic [KW-1:0]              r_send;
    logic [WW-1:0]              r_word;
    logic [WW-1:0]              r_mask;
    logic [fowo_pkg::ACC_W-1:0] r_acc;

    // output register
    logic                                r_out_valid;
    logic [fowo_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                                r_out_user;
    logic                                r_out_last;

    logic [KW-1:0]               w_k;
    logic [KW-1:0]               w_idx_ext;
    logic                        w_idx_ok;
    logic [WW-1:0]               w_bit;
    logic                        w_occ_bit;
    logic                        w_parity;
    logic                        w_slice_bad;
    logic [KW-1:0]               w_len;
    logic [WW-1:0]               w_lmask;
    logic [WW-1:0]               w_prep_mask;
    logic [WW-1:0]               w_iso;
    logic [WW-1:0]               w_mask_rest;
    logic [fowo_pkg::IDX_W-1:0]  w_pos;
    logic [fowo_pkg::STAT_W-1:0] w_status;
    logic                        w_flag;
    logic [WW-1:0]               w_value;
    logic                        w_out_free;
    logic                        w_list_last;
    fowo_pkg::t_op_class         w_op_class;

    // effective orbital count and index checks
    assign w_k         = (r_orbital_count > K_MAX) ? K_MAX : r_orbital_count;
    assign w_idx_ext   = {1'b0, r_idx};
    assign w_idx_ok    = w_idx_ext < w_k;
    assign w_bit       = WW'(1) << r_idx;
    assign w_occ_bit   = r_occ[r_idx];
    assign w_parity    = ^(r_occ & (w_bit - WW'(1)));
    assign w_slice_bad = (r_send <= w_idx_ext) || (r_send > w_k);
    assign w_len       = r_send - w_idx_ext;
    assign w_lmask     = w_len[KW-1] ? '1 : ((WW'(1) << w_len[KW-2:0]) - WW'(1));

    // lowest set position of the list mask
    assign w_iso       = r_mask & (~r_mask + WW'(1));
    assign w_mask_rest = r_mask & (r_mask - WW'(1));
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < WW; i++) begin
            if (w_iso[i]) begin
                w_pos = w_pos | fowo_pkg::IDX_W'(i);
            end
        end
    end

    // operation class and mask prepared in decode
    always_comb begin
        w_op_class  = fowo_pkg::CLASS_SINGLE;
        w_prep_mask = r_word;
        unique case (r_op)
            fowo_pkg::OP_LOAD: begin
                w_op_class  = fowo_pkg::CLASS_COUNT;
                w_prep_mask = r_word;
            end
            fowo_pkg::OP_COUNT_DIFF: begin
                w_op_class  = fowo_pkg::CLASS_COUNT;
                w_prep_mask = r_occ ^ r_word;
            end
            fowo_pkg::OP_LIST_DIFF: begin
                w_op_class  = fowo_pkg::CLASS_LIST;
                w_prep_mask = (r_occ ^ r_word) & r_occ;
            end
            fowo_pkg::OP_LIST_MATCH: begin
                w_op_class  = fowo_pkg::CLASS_LIST;
                w_prep_mask = r_occ & r_word;
            end
            fowo_pkg::OP_LIST_OCC: begin
                w_op_class  = fowo_pkg::CLASS_LIST;
                w_prep_mask = r_occ;
            end
            default: begin
                w_op_class = fowo_pkg::CLASS_SINGLE;
            end
        endcase
    end

    // status to the controller: op_class, out_free, list_last from the top bit down
    assign w_out_free  = !r_out_valid || i_m_ready;
    assign w_list_last = (w_mask_rest == '0);
    assign o_sts       = {w_op_class, w_out_free, w_list_last};

    // single-result outcome and state update
    always_comb begin
        n_occ    = r_occ;
        n_sign   = r_sign;
        w_status = fowo_pkg::STATUS_OK;
        w_flag   = 1'b1;
        w_value  = '0;
        unique case (r_op)
            fowo_pkg::OP_LOAD: begin
                n_occ = r_word;
                if (KW'(r_acc) != r_electron_count) begin
                    w_status = fowo_pkg::STATUS_MISMATCH;
                    w_flag   = 1'b0;
                end
            end
            fowo_pkg::OP_CREATE, fowo_pkg::OP_ANNIHILATE: begin
                if (!w_idx_ok) begin
                    w_status = fowo_pkg::STATUS_RANGE;
                    w_flag   = 1'b0;
                end else if ((r_op == fowo_pkg::OP_CREATE) == w_occ_bit) begin
                    w_status = fowo_pkg::STATUS_NA;
                    w_flag   = 1'b0;
                end else begin
                    n_occ  = r_occ ^ w_bit;
                    n_sign = r_sign ^ w_parity;
                end
            end
            fowo_pkg::OP_TEST: begin
                if (!w_idx_ok) begin
                    w_status = fowo_pkg::STATUS_RANGE;
                    w_flag   = 1'b0;
                end else begin
                    w_flag = w_occ_bit;
                end
            end
            fowo_pkg::OP_SLICE: begin
                if (w_slice_bad) begin
                    w_status = fowo_pkg::STATUS_BAD_SLICE;
                    w_flag   = 1'b0;
                end else begin
                    w_value = (r_occ >> r_idx) & w_lmask;
                end
            end
            fowo_pkg::OP_COUNT_DIFF: begin
                w_value = WW'(r_acc);
            end
            default: begin
                w_status = fowo_pkg::STATUS_NA;
                w_flag   = 1'b0;
            end
        endcase
    end

    // configuration, word and sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital_count  <= KW'(64);
            r_electron_count <= '0;
            r_occ            <= '0;
            r_sign           <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    fowo_pkg::CFG_ORBITAL_COUNT:  r_orbital_count  <= i_cfg_wr_data;
                    fowo_pkg::CFG_ELECTRON_COUNT: r_electron_count <= i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_cmd.emit_single) begin
                r_occ  <= n_occ;
                r_sign <= n_sign;
            end
        end
    end

    // item capture, mask and popcount accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_s_data[fowo_pkg::IN_OP_LSB   +: fowo_pkg::OP_W];
            r_idx  <= i_s_data[fowo_pkg::IN_IDX_LSB  +: fowo_pkg::IDX_W];
            r_send <= i_s_data[fowo_pkg::IN_END_LSB  +: KW];
            r_word <= i_s_data[fowo_pkg::IN_WORD_LSB +: WW];
        end
        if (i_cmd.prep) begin
            r_mask <= w_prep_mask;
            r_acc  <= '0;
        end else if (i_cmd.count_step) begin
            r_mask <= r_mask >> fowo_pkg::CHUNK_W;
            r_acc  <= r_acc + fowo_pkg::ACC_W'(fowo_pkg::popcount16(
                          r_mask[fowo_pkg::CHUNK_W-1:0]));
        end else if (i_cmd.emit_list) begin
            r_mask <= w_mask_rest;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_list) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word: sign, value, flag, status from the top bit down
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_out_data <= {{PAD_W{1'b0}}, n_sign, w_value, w_flag, w_status};
            r_out_user <= 1'b0;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_list) begin
            r_out_data <= {{PAD_W{1'b0}}, r_sign, WW'(w_pos), 1'b1,
                           fowo_pkg::STATUS_OK};
            r_out_user <= (r_mask == '0);
            r_out_last <= (w_mask_rest == '0);
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_user;
    assign o_m_last  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/fermion_occupation_word_ops_unit.sv =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops unit - top level
// Keeps an occupation word and sign; loads, creates, annihilates, tests,
// slices, counts differences and lists set positions as word runs.
// ----------------------------------------------------------------------------
//  port group   dir  word contents (lowest bit up)
//  s_axis_*     in   operation, orbital_index, slice_end, word
//  m_axis_*     out  status, flag, result_value, sign_negative; tuser run_empty;
//                    tlast last
//  i_cfg_*      in   index 0 orbital_count, index 1 electron_count
//
// One item at a time: accept, decode, then a result; test, create,
// annihilate and slice go straight to the result, load and count diff run
// the popcount first (16 bits per cycle), lists give one word per position.
// Reset is synchronous, active low; it clears word and sign and sets the
// config to 64 orbitals and 0 electrons.
// A stalled output register holds the controller until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fermion_occupation_word_ops_unit #(
    parameter int MAX_ORBITALS = fowo_pkg::MAX_ORBITALS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // config write port
    input  wire                                 i_cfg_wr_en,
    input  wire  [fowo_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  wire  [fowo_pkg::CFG_W-1:0]          i_cfg_wr_data,
    // input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[3:0], orbital_index[9:4], slice_end[16:10], word[80:17]
    input  wire  [fowo_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // status[2:0], flag[3], result_value[67:4], sign_negative[68]
    output logic [fowo_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // run_empty[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    fowo_pkg::t_cmd w_cmd;
    fowo_pkg::t_sts w_sts;

    // controller
    fowo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (w_sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    // datapath
    fowo_dp #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_data      (s_axis_tdata),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_m_data      (m_axis_tdata),
        .o_m_user      (m_axis_tuser),
        .o_m_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fowo_checker.sv =====
// ----------------------------------------------------------------------------
// Fermion occupation word ops - port checker
// Watches the result stream of the top level; bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fermion_occupation_word_ops_unit_defines.svh"

module fowo_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_m_valid,
    input wire                              i_m_ready,
    input wire [fowo_pkg::OUT_DATA_W-1:0]   i_m_data,
    input wire                              i_m_user,
    input wire                              i_m_last
);

    logic [fowo_pkg::STAT_W-1:0] w_status;
    logic                        w_flag;
    logic [fowo_pkg::WORD_W-1:0] w_value;

    assign w_status = i_m_data[fowo_pkg::OUT_STAT_LSB +: fowo_pkg::STAT_W];
    assign w_flag   = i_m_data[fowo_pkg::OUT_FLAG_POS];
    assign w_value  = i_m_data[fowo_pkg::OUT_VALUE_LSB +: fowo_pkg::WORD_W];

    // stalled result word holds
    `FOWO_ASSERT_NEXT(a_out_hold, i_m_valid && !i_m_ready, i_m_valid && $stable(i_m_data) && $stable(i_m_user) && $stable(i_m_last))

    // an empty run is a single closing word
    `FOWO_ASSERT_NOW(a_empty_last, i_m_valid && i_m_user, i_m_last)

    // an empty run carries ok, flag set and no position
    `FOWO_ASSERT_NOW(a_empty_fields, i_m_valid && i_m_user, (w_status == fowo_pkg::STATUS_OK) && w_flag && (w_value == '0))

    // any error status clears the flag
    `FOWO_ASSERT_NOW(a_err_flag, i_m_valid && (w_status != fowo_pkg::STATUS_OK), !w_flag)

endmodule

bind fermion_occupation_word_ops_unit fowo_checker u_fowo_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_valid (m_axis_tvalid),
    .i_m_ready (m_axis_tready),
    .i_m_data  (m_axis_tdata),
    .i_m_user  (m_axis_tuser),
    .i_m_last  (m_axis_tlast)
);

`default_nettype wire
